// ----- src/obc_pkg.sv -----
// shared constants, types and helpers of the optimal binary search tree cost block
`default_nettype none
package obc_pkg;

  localparam int unsigned MAX_KEYS = 16;
  localparam int unsigned KEY_W    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned COST_W   = 24;
  localparam int unsigned KC_W     = 5;
  localparam int unsigned SUM_W    = FREQ_W + CNT_W;
  localparam int unsigned PAIR_W   = COST_W + 1;
  localparam int unsigned TOT_W    = COST_W + 2;
  localparam int unsigned ADDR_W   = 2 * KEY_W;
  localparam int unsigned TBL_DEPTH = 2 ** ADDR_W;
  localparam int unsigned KC_MAX   = 2 ** KC_W - 1;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_ACC,
    ST_WR,
    ST_DONE
  } obc_state_e;

  // clamp a range cost to the table width
  function automatic logic [COST_W-1:0] sat_cost(input logic [TOT_W-1:0] v);
    logic [COST_W-1:0] r;
    if (v > TOT_W'(COST_MAX)) begin
      r = COST_MAX;
    end else begin
      r = v[COST_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/optimal_bst_cost.sv -----
// top level: optimal binary search tree cost over a streamed key set
//
// input channel: in_valid_i / in_stall_o carry frequency_i and last_key_i,
// one key per transaction in sorted key order; last_key_i closes the set.
// keys beyond MAX_KEYS are dropped and reported through overflow_o.
// output channel: out_valid_o / out_stall_i carry optimal_cost_o,
// key_count_o and overflow_o, one transaction per key set.
// while keys load, one key is taken per cycle.  after the last key the
// cost table is filled under a small sequencer, one root of one range at
// a time: a read state, then an accumulate state for each root, and one
// write state per range, for range lengths 1 up to the key count.  then
// the result moves into the output register.  the cost table is a one-write,
// two-read memory with registered read data.
// in_stall_o is high from the last key until the result moves into the
// output register; a stalled result holds and the next key set may load.
// a finished fill waits while the previous result is still stalled.
// reset clears the sequencer, key count, overflow flag and output valid;
// the frequency store and cost table need no clearing since the fill
// only reads entries it wrote before.
`default_nettype none
module optimal_bst_cost (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [obc_pkg::FREQ_W-1:0]  frequency_i,
  input  wire logic                        last_key_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [obc_pkg::COST_W-1:0]       optimal_cost_o,
  output logic [obc_pkg::KC_W-1:0]         key_count_o,
  output logic                             overflow_o
);
  import obc_pkg::*;

  // sequencer and control
  obc_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;        // keys held in the store
  logic              ovf_q, ovf_d;        // a key was dropped in this set
  logic [CNT_W-1:0]  len_q, len_d;        // current range length
  logic [KEY_W-1:0]  i_q, i_d;            // range start
  logic [KEY_W-1:0]  r_q, r_d;            // current root
  logic              out_valid_q, out_valid_d;

  // datapath
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [PAIR_W-1:0] best_q, best_d;
  logic [COST_W-1:0] res_cost_q, res_cost_d;
  logic [COST_W-1:0] out_cost_q, out_cost_d;
  logic [KC_W-1:0]   out_kc_q, out_kc_d;
  logic              out_ovf_q, out_ovf_d;
  logic              l_empty_q, r_empty_q;
  logic [FREQ_W-1:0] freq_rd_q;
  logic [COST_W-1:0] rd_l_q, rd_r_q;

  // storage
  logic [FREQ_W-1:0] freq_mem [MAX_KEYS];
  logic [COST_W-1:0] cost_mem [TBL_DEPTH];

  logic              in_acc, out_take, load_en, wr_en;
  logic [KEY_W-1:0]  j;
  logic [ADDR_W-1:0] rd_addr_l, rd_addr_r, wr_addr;
  logic [COST_W-1:0] wr_data;
  logic [PAIR_W-1:0] pair_cost;
  logic [CNT_W-1:0]  next_end;
  logic [31:0]       kc_wide;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign load_en    = in_acc && (cnt_q < CNT_W'(MAX_KEYS));

  // end index of the current range, always below the key count
  assign j = KEY_W'(i_q + len_q[KEY_W-1:0] - KEY_W'(1));

  // subrange addresses for the current root; empty sides are masked later
  assign rd_addr_l = {i_q, KEY_W'(r_q - KEY_W'(1))};
  assign rd_addr_r = {KEY_W'(r_q + KEY_W'(1)), j};
  assign wr_addr   = {i_q, j};
  assign wr_data   = sat_cost(TOT_W'(sum_q) + TOT_W'(best_q));
  assign wr_en     = (state_q == ST_WR);

  // left plus right subrange cost of this root
  assign pair_cost = (l_empty_q ? PAIR_W'(0) : PAIR_W'(rd_l_q)) +
                     (r_empty_q ? PAIR_W'(0) : PAIR_W'(rd_r_q));

  // one past the end of the next range at the same length
  assign next_end = CNT_W'(i_q) + len_q + CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    len_d       = len_q;
    i_d         = i_q;
    r_d         = r_q;
    sum_d       = sum_q;
    best_d      = best_q;
    res_cost_d  = res_cost_q;
    out_cost_d  = out_cost_q;
    out_kc_d    = out_kc_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q && !out_take;
    kc_wide     = 32'(cnt_q);

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (load_en) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_key_i) begin
            len_d   = CNT_W'(1);
            i_d     = '0;
            r_d     = '0;
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        sum_d = ((r_q == i_q) ? SUM_W'(0) : sum_q) + SUM_W'(freq_rd_q);
        if ((r_q == i_q) || (pair_cost < best_q)) begin
          best_d = pair_cost;
        end
        if (r_q == j) begin
          state_d = ST_WR;
        end else begin
          r_d     = r_q + KEY_W'(1);
          state_d = ST_RD;
        end
      end
      ST_WR: begin
        if (len_q == cnt_q) begin
          // the whole key range is the final entry
          res_cost_d = wr_data;
          state_d    = ST_DONE;
        end else if (next_end <= cnt_q) begin
          i_d     = i_q + KEY_W'(1);
          r_d     = i_q + KEY_W'(1);
          state_d = ST_RD;
        end else begin
          len_d   = len_q + CNT_W'(1);
          i_d     = '0;
          r_d     = '0;
          state_d = ST_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_cost_d  = res_cost_q;
          out_kc_d    = (kc_wide > 32'(KC_MAX)) ? KC_W'(KC_MAX) : kc_wide[KC_W-1:0];
          out_ovf_d   = ovf_q;
          cnt_d       = '0;
          ovf_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    i_q        <= i_d;
    r_q        <= r_d;
    sum_q      <= sum_d;
    best_q     <= best_d;
    res_cost_q <= res_cost_d;
    out_cost_q <= out_cost_d;
    out_kc_q   <= out_kc_d;
    out_ovf_q  <= out_ovf_d;
    l_empty_q  <= (r_q == i_q);
    r_empty_q  <= (r_q == j);
    freq_rd_q  <= freq_mem[r_q];
  end

  // frequency store
  always_ff @(posedge clk_i) begin
    if (load_en) begin
      freq_mem[cnt_q[KEY_W-1:0]] <= frequency_i;
    end
  end

  // cost table: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cost_mem[wr_addr] <= wr_data;
    end
    rd_l_q <= cost_mem[rd_addr_l];
    rd_r_q <= cost_mem[rd_addr_r];
  end

  assign out_valid_o    = out_valid_q;
  assign optimal_cost_o = out_cost_q;
  assign key_count_o    = out_kc_q;
  assign overflow_o     = out_ovf_q;

  // a result always covers at least one key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (key_count_o != '0))
    else $error("result with zero key count");

  // the key count holds during the table fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD || state_q == ST_ACC || state_q == ST_WR) |=> $stable(cnt_q))
    else $error("key count changed during fill");

  // the root stays inside the current range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD || state_q == ST_ACC) |-> (r_q >= i_q && r_q <= j))
    else $error("root outside range");

  // range length stays within the loaded key count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> (len_q != '0 && len_q <= cnt_q))
    else $error("range length out of bounds");

endmodule
`default_nettype wire
